FILE: design/mvm_pkg.sv
// Shared types and constants for the matrix-vector multiply block.
// No dependencies; imported by mvm_acc, matrix_vector_multiply and the testbench.
package mvm_pkg;

  localparam int ROW_FIELD_W = 6;
  localparam int COL_FIELD_W = 6;
  localparam int VALUE_W     = 16;
  localparam int PROD_W      = 32;
  localparam int ACC_W       = 38;
  localparam int CNT_W       = 7;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 48;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_ELEM  = 1'b1;

  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  typedef struct packed {
    logic                   rd_en;
    logic [ROW_FIELD_W-1:0] rd_row;
    logic                   acc_en;
    logic [ROW_FIELD_W-1:0] acc_row;
    logic                   clr;
  } acc_ctl_t;

endpackage

FILE: design/mvm_acc.sv
// Row accumulator memory with per-row valid flags and the 38-bit adder.
// Depends on mvm_pkg.
module mvm_acc
  import mvm_pkg::*;
#(
  parameter int MAX_ROWS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  acc_ctl_t                 ctl,
  input  logic signed [PROD_W-1:0] addend,
  output logic signed [ACC_W-1:0]  rd_q
);

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [ACC_W-1:0]    acc_mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] vld_r;
  logic [ACC_W-1:0]    q_r;
  logic [ACC_W-1:0]    sum;
  logic [ROW_W-1:0]    rd_idx;
  logic [ROW_W-1:0]    wr_idx;

  assign rd_idx = ROW_W'(ctl.rd_row);
  assign wr_idx = ROW_W'(ctl.acc_row);
  assign sum    = q_r + {{(ACC_W-PROD_W){addend[PROD_W-1]}}, addend};
  assign rd_q   = q_r;

  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      acc_mem[wr_idx] <= sum;
    end
    if (ctl.rd_en) begin
      q_r <= vld_r[rd_idx] ? acc_mem[rd_idx] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      vld_r <= '0;
    end else if (ctl.acc_en) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

endmodule

FILE: design/matrix_vector_multiply.sv
// Matrix-vector multiply top level: matrix store, sequencer, shared MAC.
// Depends on mvm_pkg and mvm_acc.
// A matrix write is stored when taken. A vector element holds in_tready low while its
// rows go, one row per cycle, through the single multiply-accumulate and the store read port.
// On the final element the row results then go out one word at a time, each row read and
// loaded only once the last word is taken. One input word is in flight at a time.
// Reset: control, element count and accumulator flags cleared; matrix store undefined.
module matrix_vector_multiply
  import mvm_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // row_index[5:0], col_index[11:6], value[27:12]
  input  logic                  in_tuser,   // command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // result_row[5:0], dot_sum[43:6]
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CNT_W-1:0]      cfg_data
);

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MAC     = 3'd1;
  localparam logic [2:0] S_DRAIN   = 3'd2;
  localparam logic [2:0] S_EMIT_RD = 3'd3;
  localparam logic [2:0] S_EMIT_LD = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        num_rows_r, num_cols_r;
  logic [CNT_W-1:0]        rows_clamp, cols_clamp;
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        rows_r;
  logic [CNT_W-1:0]        col_r;
  logic                    col_ok_r;
  logic                    done_r;
  logic signed [VALUE_W-1:0] elem_r;
  logic [ROW_W-1:0]        mac_row_r;
  logic [ROW_W-1:0]        emit_row_r;
  logic                    s1_v_r, s2_v_r;
  logic [ROW_W-1:0]        s1_row_r, s2_row_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic [VALUE_W-1:0]      mem_q_r;
  logic [VALUE_W-1:0]      store [DEPTH];

  logic                    in_cmd;
  logic [ROW_FIELD_W-1:0]  in_row;
  logic [COL_FIELD_W-1:0]  in_col;
  logic [VALUE_W-1:0]      in_value;
  logic                    in_acc;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr, rd_addr;
  logic                    mac_last_row;
  logic                    emit_last_row;

  logic                    out_valid_r;
  logic [ROW_FIELD_W-1:0]  out_row_r;
  logic [ACC_W-1:0]        out_sum_r;
  logic                    out_last_r;

  acc_ctl_t                acc_ctl;
  logic signed [ACC_W-1:0] acc_q;

  assign in_cmd   = in_tuser;
  assign in_row   = in_tdata[5:0];
  assign in_col   = in_tdata[11:6];
  assign in_value = in_tdata[27:12];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (num_rows_r == '0) begin
      rows_clamp = CNT_W'(1);
    end else if (32'(num_rows_r) > MAX_ROWS) begin
      rows_clamp = CNT_W'(MAX_ROWS);
    end else begin
      rows_clamp = num_rows_r;
    end
    if (num_cols_r == '0) begin
      cols_clamp = CNT_W'(1);
    end else if (32'(num_cols_r) > MAX_COLS) begin
      cols_clamp = CNT_W'(MAX_COLS);
    end else begin
      cols_clamp = num_cols_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= CNT_W'(64);
      num_cols_r <= CNT_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUM_ROWS: num_rows_r <= cfg_data;
        REG_NUM_COLS: num_cols_r <= cfg_data;
      endcase
    end
  end

  // Matrix store: one write port for loads, one registered read port for the MAC
  assign wr_en   = in_acc && (in_cmd == CMD_WRITE) && (32'(in_row) < MAX_ROWS)
                   && (32'(in_col) < MAX_COLS);
  assign wr_addr = ADDR_W'(in_row) * ADDR_W'(MAX_COLS) + ADDR_W'(in_col);
  assign rd_addr = ADDR_W'(mac_row_r) * ADDR_W'(MAX_COLS) + ADDR_W'(col_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= in_value;
    end
    if (state_r == S_MAC) begin
      mem_q_r <= store[rd_addr];
    end
  end

  assign mac_last_row  = (CNT_W'(mac_row_r) + CNT_W'(1)) == rows_r;
  assign emit_last_row = (CNT_W'(emit_row_r) + CNT_W'(1)) == rows_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_acc && in_cmd == CMD_ELEM) state_nxt = S_MAC;
      S_MAC:     if (mac_last_row) state_nxt = S_DRAIN;
      S_DRAIN: begin
        if (!s1_v_r && !s2_v_r) state_nxt = done_r ? S_EMIT_RD : S_IDLE;
      end
      S_EMIT_RD: if (!out_valid_r) state_nxt = S_EMIT_LD;
      S_EMIT_LD: state_nxt = emit_last_row ? S_IDLE : S_EMIT_RD;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      mac_row_r  <= '0;
      emit_row_r <= '0;
      done_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= (state_r == S_MAC);
      s2_v_r  <= s1_v_r;
      if (in_acc && in_cmd == CMD_ELEM) begin
        done_r     <= ({1'b0, cnt_r} + 8'd1) >= {1'b0, cols_clamp};
        cnt_r      <= (({1'b0, cnt_r} + 8'd1) >= {1'b0, cols_clamp}) ? '0 : cnt_r + CNT_W'(1);
        mac_row_r  <= '0;
        emit_row_r <= '0;
      end
      if (state_r == S_MAC) begin
        mac_row_r <= mac_row_r + ROW_W'(1);
      end
      if (state_r == S_EMIT_LD) begin
        emit_row_r <= emit_row_r + ROW_W'(1);
      end
    end
  end

  assign prod_nxt = $signed(mem_q_r) * elem_r;

  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == CMD_ELEM) begin
      elem_r   <= $signed(in_value);
      rows_r   <= rows_clamp;
      col_r    <= cnt_r;
      col_ok_r <= 32'(cnt_r) < MAX_COLS;
    end
    s1_row_r <= mac_row_r;
    s2_row_r <= s1_row_r;
    prod_r   <= col_ok_r ? prod_nxt : '0;
  end

  always_comb begin
    acc_ctl.rd_en   = s1_v_r || (state_r == S_EMIT_RD && !out_valid_r);
    acc_ctl.rd_row  = s1_v_r ? ROW_FIELD_W'(s1_row_r) : ROW_FIELD_W'(emit_row_r);
    acc_ctl.acc_en  = s2_v_r;
    acc_ctl.acc_row = ROW_FIELD_W'(s2_row_r);
    acc_ctl.clr     = (state_r == S_EMIT_LD) && emit_last_row;
  end

  mvm_acc #(
    .MAX_ROWS (MAX_ROWS)
  ) u_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (acc_ctl),
    .addend (prod_r),
    .rd_q   (acc_q)
  );

  // Output word register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT_LD) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT_LD) begin
      out_row_r  <= ROW_FIELD_W'(emit_row_r);
      out_sum_r  <= acc_q;
      out_last_r <= emit_last_row;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-ACC_W-ROW_FIELD_W){1'b0}}, out_sum_r, out_row_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) < MAX_COLS)
    else $error("element count reached column limit");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT_LD |-> !out_valid_r)
    else $error("result loaded over a waiting word");

  a_acc_only_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (state_r == S_MAC || state_r == S_DRAIN))
    else $error("accumulator update outside element pass");

  a_acc_row_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> CNT_W'(s2_row_r) < rows_r)
    else $error("accumulator update beyond rows in use");

  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> !(state_r == S_EMIT_RD))
    else $error("accumulator read port claimed twice");
`endif

endmodule

FILE: tb/matrix_vector_multiply_test.sv
// Self-checking testbench for matrix_vector_multiply: a directed table, then random phases.
// The first four columns of every row are filled first and no element ever reads past them.
// Depends on mvm_pkg and the matrix_vector_multiply RTL.
module matrix_vector_multiply_test;
  import mvm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [5:0]         row;
    logic signed [37:0] sum;
    logic               last;
  } row_result_t;

  typedef enum logic {STEP_REG, STEP_WORD} step_kind_t;

  typedef struct {
    step_kind_t         kind;
    logic               reg_idx;
    logic [6:0]         reg_val;
    logic               cmd;
    logic [5:0]         row;
    logic [5:0]         col;
    logic [15:0]        val;
    bit                 typed;
    logic signed [37:0] typed_sum;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_index;
  logic [CNT_W-1:0]      cfg_data;

  logic signed [15:0] shadow_matrix [64][64];
  logic signed [37:0] shadow_acc [64];
  logic [6:0]         shadow_count;
  logic [6:0]         shadow_rows;
  logic [6:0]         shadow_cols;

  row_result_t pending_sums[$];
  stim_row_t   plan[$];
  int          mismatch_count = 0;
  bit          quiet = 1'b0;
  int          stall_left = 0;
  int          sent;
  int          len;
  int          phase;
  row_result_t want;
  row_result_t patched;
  logic [5:0]         got_row;
  logic signed [37:0] got_sum;

  matrix_vector_multiply dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned clamp_count(logic [6:0] v);
    if (v == 7'd0) return 1;
    if (v > 7'd64) return 64;
    return v;
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_value();
    unique case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [6:0] pick_count();
    unique case ($urandom_range(0, 19))
      0: return 7'd0;
      1: return 7'd64;
      2: return 7'($urandom_range(65, 127));
      3: return 7'd1;
      4, 5: return 7'($urandom_range(9, 64));
      default: return 7'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [6:0] pick_cols();
    return 7'($urandom_range(0, 4));
  endfunction

  function automatic stim_row_t reg_row(logic idx, logic [6:0] data);
    stim_row_t s;
    s = '{kind: STEP_REG, reg_idx: idx, reg_val: data, cmd: CMD_WRITE, row: 6'd0,
          col: 6'd0, val: 16'd0, typed: 1'b0, typed_sum: 38'sd0};
    return s;
  endfunction

  function automatic stim_row_t word_row(logic cmd, logic [5:0] row, logic [5:0] col,
                                         logic [15:0] val, bit typed,
                                         logic signed [37:0] sum);
    stim_row_t s;
    s = '{kind: STEP_WORD, reg_idx: REG_NUM_ROWS, reg_val: 7'd0, cmd: cmd, row: row,
          col: col, val: val, typed: typed, typed_sum: sum};
    return s;
  endfunction

  task automatic apply_word(logic cmd, logic [5:0] row, logic [5:0] col,
                            logic signed [15:0] val);
    int unsigned rows;
    int unsigned cols;
    logic signed [15:0] entry;
    row_result_t res;
    rows = clamp_count(shadow_rows);
    cols = clamp_count(shadow_cols);
    if (cmd == CMD_WRITE) begin
      shadow_matrix[row][col] = val;
    end else begin
      for (int r = 0; r < rows; r++) begin
        entry = (shadow_count < 7'd64) ? shadow_matrix[r][shadow_count[5:0]] : 16'sd0;
        shadow_acc[r] = shadow_acc[r] + entry * val;
      end
      shadow_count = shadow_count + 7'd1;
      if (shadow_count >= cols) begin
        for (int r = 0; r < rows; r++) begin
          res.row  = r[5:0];
          res.sum  = shadow_acc[r];
          res.last = (r + 1 == rows);
          pending_sums.push_back(res);
        end
        for (int r = 0; r < 64; r++) shadow_acc[r] = 38'sd0;
        shadow_count = 7'd0;
      end
    end
  endtask

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  // hold the input side low until every pending sum has come out, then let the block settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] data);
    drain_results();
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_NUM_ROWS) shadow_rows = data;
    else shadow_cols = data;
    @(negedge clk);
  endtask

  task automatic send_word(logic cmd, logic [5:0] row, logic [5:0] col, logic [15:0] val);
    int unsigned g;
    g = (!quiet && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tdata  <= {4'b0000, val, col, row};
    in_tuser  <= cmd;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    apply_word(cmd, row, col, val);
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = pick_gap() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_row = out_tdata[5:0];
      got_sum = out_tdata[43:6];
      if (pending_sums.size() == 0) begin
        note_mismatch($sformatf("unexpected word row %0d sum %0d last %0b",
                                got_row, got_sum, out_tlast));
      end else begin
        want = pending_sums.pop_front();
        if (want.row !== got_row)
          note_mismatch($sformatf("row: expected %0d, got %0d", want.row, got_row));
        if (want.sum !== got_sum)
          note_mismatch($sformatf("row %0d sum: expected %0d, got %0d",
                                  want.row, want.sum, got_sum));
        if (want.last !== out_tlast)
          note_mismatch($sformatf("row %0d last: expected %0b, got %0b",
                                  want.row, want.last, out_tlast));
      end
    end
  end

  initial begin
    #200_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = 1'b0;
    cfg_data   = '0;
    out_tready = 1'b0;
    shadow_rows  = 7'd64;
    shadow_cols  = 7'd64;
    shadow_count = 7'd0;
    for (int r = 0; r < 64; r++) shadow_acc[r] = 38'sd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // load the first four columns of every row; no read ever reaches a later column
    for (int r = 0; r < 64; r++)
      for (int c = 0; c < 4; c++)
        send_word(CMD_WRITE, 6'(r), 6'(c), pick_value());
    repeat (3) send_word(CMD_ELEM, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                         pick_value());
    write_reg(REG_NUM_COLS, 7'd4);
    send_word(CMD_ELEM, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), pick_value());

    plan.push_back(reg_row(REG_NUM_ROWS, 7'd1));
    plan.push_back(reg_row(REG_NUM_COLS, 7'd1));
    plan.push_back(word_row(CMD_WRITE, 6'd0, 6'd0, 16'h8000, 1'b0, 38'sd0));
    plan.push_back(word_row(CMD_ELEM, 6'd0, 6'd0, 16'h8000, 1'b1, 38'sd1073741824));
    plan.push_back(word_row(CMD_WRITE, 6'd0, 6'd0, 16'h7fff, 1'b0, 38'sd0));
    plan.push_back(word_row(CMD_ELEM, 6'd63, 6'd63, 16'h8000, 1'b1, -38'sd1073709056));
    plan.push_back(word_row(CMD_ELEM, 6'd0, 6'd0, 16'h7fff, 1'b1, 38'sd1073676289));
    plan.push_back(word_row(CMD_WRITE, 6'd0, 6'd0, 16'h0000, 1'b0, 38'sd0));
    plan.push_back(word_row(CMD_ELEM, 6'd0, 6'd0, 16'hffff, 1'b1, 38'sd0));
    plan.push_back(reg_row(REG_NUM_ROWS, 7'd0));
    plan.push_back(reg_row(REG_NUM_COLS, 7'd0));
    plan.push_back(word_row(CMD_ELEM, 6'd0, 6'd0, 16'h7fff, 1'b1, 38'sd0));
    plan.push_back(word_row(CMD_WRITE, 6'd63, 6'd63, 16'hffff, 1'b0, 38'sd0));
    plan.push_back(word_row(CMD_WRITE, 6'd63, 6'd62, 16'h8000, 1'b0, 38'sd0));
    plan.push_back(reg_row(REG_NUM_ROWS, 7'd127));
    plan.push_back(reg_row(REG_NUM_COLS, 7'd2));
    plan.push_back(word_row(CMD_ELEM, 6'd0, 6'd0, 16'h8000, 1'b0, 38'sd0));
    plan.push_back(word_row(CMD_ELEM, 6'd0, 6'd0, 16'h7fff, 1'b0, 38'sd0));
    plan.push_back(reg_row(REG_NUM_ROWS, 7'd3));
    plan.push_back(reg_row(REG_NUM_COLS, 7'd4));
    plan.push_back(word_row(CMD_ELEM, 6'd0, 6'd0, 16'd100, 1'b0, 38'sd0));
    plan.push_back(word_row(CMD_ELEM, 6'd0, 6'd0, 16'hff38, 1'b0, 38'sd0));
    plan.push_back(reg_row(REG_NUM_COLS, 7'd2));
    plan.push_back(word_row(CMD_ELEM, 6'd0, 6'd0, 16'd300, 1'b0, 38'sd0));
    plan.push_back(reg_row(REG_NUM_COLS, 7'd4));
    plan.push_back(word_row(CMD_ELEM, 6'd0, 6'd0, 16'h1234, 1'b0, 38'sd0));
    plan.push_back(word_row(CMD_ELEM, 6'd0, 6'd0, 16'hedcb, 1'b0, 38'sd0));
    plan.push_back(reg_row(REG_NUM_ROWS, 7'd2));
    plan.push_back(word_row(CMD_ELEM, 6'd0, 6'd0, 16'h7fff, 1'b0, 38'sd0));
    plan.push_back(word_row(CMD_ELEM, 6'd0, 6'd0, 16'h8000, 1'b0, 38'sd0));
    plan.push_back(word_row(CMD_ELEM, 6'd0, 6'd0, 16'h0001, 1'b0, 38'sd0));
    plan.push_back(reg_row(REG_NUM_ROWS, 7'd127));
    plan.push_back(reg_row(REG_NUM_COLS, 7'd127));
    plan.push_back(word_row(CMD_ELEM, 6'd0, 6'd0, 16'h4000, 1'b0, 38'sd0));
    plan.push_back(word_row(CMD_ELEM, 6'd0, 6'd0, 16'hc000, 1'b0, 38'sd0));
    plan.push_back(reg_row(REG_NUM_COLS, 7'd4));
    plan.push_back(word_row(CMD_ELEM, 6'd0, 6'd0, 16'h2000, 1'b0, 38'sd0));

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_REG) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_word(plan[i].cmd, plan[i].row, plan[i].col, plan[i].val);
        if (plan[i].typed) begin
          patched = pending_sums.pop_back();
          patched.sum = plan[i].typed_sum;
          pending_sums.push_back(patched);
        end
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < 170) begin
      quiet = ($urandom_range(0, 3) == 0);
      write_reg(REG_NUM_ROWS, pick_count());
      write_reg(REG_NUM_COLS, pick_cols());
      len = $urandom_range(20, 60);
      for (int k = 0; k < len; k++) begin
        if (phase == 1 && k == len / 2) drain_results();
        if ($urandom_range(0, 3) == 0)
          send_word(CMD_WRITE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                    pick_value());
        else
          send_word(CMD_ELEM, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                    pick_value());
        sent++;
      end
      phase++;
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/mvm_pkg.sv
design/mvm_acc.sv
design/matrix_vector_multiply.sv
tb/matrix_vector_multiply_test.sv
